>>> hw/rtl/fsh_pkg.sv
package fsh_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int WIDTH_W     = 11;
	localparam int HEIGHT_W    = 16;
	localparam int PIX_W       = 8;
	localparam int ERR_W       = 9;
	localparam int CARRY_W     = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int OUT_DEPTH   = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd512;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd512;

	localparam logic [3:0] K_RIGHT  = 4'd7;
	localparam logic [3:0] K_BEHIND = 4'd3;
	localparam logic [3:0] K_BELOW  = 4'd5;
	localparam logic [3:0] K_AHEAD  = 4'd1;

	// one classified pixel between front and back
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] behind;
		logic             first;
		logic             last_col;
		logic             last_row;
		logic             top;
	} item_t;

	typedef struct packed {
		logic white;
		logic row_end;
		logic frame_end;
	} res_t;

	// k/16 of e, rounded half away from zero
	function automatic logic signed [ERR_W-1:0] share(input logic signed [CARRY_W-1:0] e,
			input logic [3:0] k);
		logic [CARRY_W-1:0] mag;
		logic [11:0]        prod;
		logic [ERR_W-1:0]   q;
		mag  = e[CARRY_W-1] ? CARRY_W'(-e) : CARRY_W'(e);
		prod = 12'(mag) * 12'(k) + 12'd8;
		q    = ERR_W'(prod[11:4]);
		share = e[CARRY_W-1] ? $signed(-q) : $signed(q);
	endfunction

endpackage

>>> hw/rtl/fsh_front.sv
module fsh_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [7:0]              pixel,
	input  logic [10:0]             image_width,
	input  logic [15:0]             image_height,
	output fsh_pkg::item_t          item
);
	import fsh_pkg::*;

	logic [WIDTH_W-1:0]  w_eff;
	logic [COL_W-1:0]    wl;
	logic [COL_W-1:0]    cnt;
	logic [COL_W-1:0]    col;
	logic [HEIGHT_W-1:0] h_last;
	logic                odd;
	logic                last_col;
	logic                last_row;
	logic [COL_W-1:0]    column_count_q;
	logic [HEIGHT_W-1:0] row_count_q;

	always_comb begin
		if (image_width == '0) begin
			w_eff = WIDTH_W'(1);
		end else if (int'(image_width) > MAX_WIDTH) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = image_width;
		end
	end

	assign wl       = COL_W'(w_eff - WIDTH_W'(1));
	assign cnt      = (column_count_q > wl) ? wl : column_count_q;
	assign h_last   = (image_height == '0) ? '0 : image_height - HEIGHT_W'(1);
	assign odd      = row_count_q[0];
	assign last_col = (cnt == wl);
	assign last_row = (row_count_q >= h_last);
	assign col      = odd ? (wl - cnt) : cnt;

	always_comb begin
		item.pixel    = pixel;
		item.col      = col;
		item.behind   = odd ? (col + COL_W'(1)) : (col - COL_W'(1));
		item.first    = (cnt == '0);
		item.last_col = last_col;
		item.last_row = last_row;
		item.top      = (row_count_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (accept) begin
			if (last_col) begin
				column_count_q <= '0;
				row_count_q    <= last_row ? '0 : row_count_q + HEIGHT_W'(1);
			end else begin
				column_count_q <= cnt + COL_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/fsh_queue.sv
module fsh_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  fsh_pkg::item_t wr_item,
	input  logic           rd,
	output logic           full,
	output logic           empty,
	output fsh_pkg::item_t head
);
	import fsh_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (int'(wptr_q) == QUEUE_DEPTH - 1) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= (int'(rptr_q) == QUEUE_DEPTH - 1) ? '0 : rptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(do_wr) - CNT_W'(do_rd);
		end
	end

endmodule

>>> hw/rtl/fsh_back.sv
module fsh_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  fsh_pkg::item_t q_head,
	output logic           q_pop,
	input  logic           pop,
	output logic           empty,
	output logic           white,
	output logic           row_end,
	output logic           frame_end
);
	import fsh_pkg::*;

	localparam int OPTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
	localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

	logic signed [ERR_W-1:0]   mem [MAX_WIDTH];
	logic signed [ERR_W-1:0]   rd_data_s1;
	item_t                     item_s1;
	logic                      valid_s1;
	logic                      fwd_s1;

	logic signed [CARRY_W-1:0] carry_q;
	logic signed [ERR_W-1:0]   pb0_q;
	logic signed [ERR_W-1:0]   pb1_q;
	logic                      pend_v_q;
	logic [COL_W-1:0]          pend_addr_q;
	logic signed [ERR_W-1:0]   pend_data_q;

	res_t                      out_q [OUT_DEPTH];
	logic [OPTR_W-1:0]         owptr_q;
	logic [OPTR_W-1:0]         orptr_q;
	logic [OCNT_W-1:0]         ocnt_q;

	logic                      step;
	logic                      s1_free;
	logic                      hit;
	logic signed [ERR_W-1:0]   below;
	logic signed [10:0]        sum;
	logic [PIX_W-1:0]          sat;
	logic                      is_white;
	logic signed [9:0]         e_wide;
	logic signed [CARRY_W-1:0] e;
	logic signed [ERR_W-1:0]   s_right;
	logic signed [ERR_W-1:0]   s_behind;
	logic signed [ERR_W-1:0]   s_below;
	logic signed [ERR_W-1:0]   s_ahead;
	logic                      wr_behind;
	logic                      creating;
	logic                      wr_en;
	logic [COL_W-1:0]          wr_addr;
	logic signed [ERR_W-1:0]   wr_data;
	logic                      out_pop;
	res_t                      res;

	assign step    = valid_s1 && (ocnt_q != OCNT_W'(OUT_DEPTH));
	assign s1_free = !valid_s1 || step;
	assign q_pop   = !q_empty && s1_free;

	// the last column of a row is held back one pixel; the next pixel reads it
	assign creating  = step && !item_s1.last_row && item_s1.last_col;
	assign wr_behind = step && !item_s1.last_row && !item_s1.first;
	assign hit = creating ? (q_head.col == item_s1.col)
	                      : (pend_v_q && (q_head.col == pend_addr_q));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_data_s1 <= mem[q_head.col];
			item_s1    <= q_head;
			fwd_s1     <= hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= q_pop;
		end
	end

	always_comb begin
		if (item_s1.top) begin
			below = '0;
		end else if (fwd_s1) begin
			below = pend_data_q;
		end else begin
			below = rd_data_s1;
		end
		sum = $signed({3'b000, item_s1.pixel}) + 11'(carry_q) + 11'(below);
		if (sum < 0) begin
			sat = '0;
		end else if (sum > 11'sd255) begin
			sat = 8'd255;
		end else begin
			sat = sum[PIX_W-1:0];
		end
		is_white = sat[PIX_W-1];
		e_wide   = $signed({2'b00, sat}) - (is_white ? 10'sd255 : 10'sd0);
		e        = e_wide[CARRY_W-1:0];
		s_right  = share(e, K_RIGHT);
		s_behind = share(e, K_BEHIND);
		s_below  = share(e, K_BELOW);
		s_ahead  = share(e, K_AHEAD);
	end

	assign wr_en   = wr_behind || pend_v_q;
	assign wr_addr = wr_behind ? item_s1.behind : pend_addr_q;
	assign wr_data = wr_behind ? (pb0_q + s_behind) : pend_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (creating) begin
			pend_addr_q <= item_s1.col;
			pend_data_q <= pb1_q + s_below;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q  <= '0;
			pb0_q    <= '0;
			pb1_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (creating) begin
				pend_v_q <= 1'b1;
			end else if (pend_v_q && !wr_behind) begin
				pend_v_q <= 1'b0;
			end
			if (step) begin
				carry_q <= item_s1.last_col ? '0 : s_right[CARRY_W-1:0];
				if (item_s1.last_col) begin
					pb0_q <= '0;
					pb1_q <= '0;
				end else if (!item_s1.last_row) begin
					pb0_q <= pb1_q + s_below;
					pb1_q <= s_ahead;
				end
			end
		end
	end

	// result buffer
	assign res.white     = is_white;
	assign res.row_end   = item_s1.last_col;
	assign res.frame_end = item_s1.last_col && item_s1.last_row;
	assign empty         = (ocnt_q == '0);
	assign out_pop       = pop && !empty;
	assign white         = out_q[orptr_q].white;
	assign row_end       = out_q[orptr_q].row_end;
	assign frame_end     = out_q[orptr_q].frame_end;

	always_ff @(posedge clk) begin
		if (step) begin
			out_q[owptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= '0;
			orptr_q <= '0;
			ocnt_q  <= '0;
		end else begin
			if (step) begin
				owptr_q <= (int'(owptr_q) == OUT_DEPTH - 1) ? '0 : owptr_q + OPTR_W'(1);
			end
			if (out_pop) begin
				orptr_q <= (int'(orptr_q) == OUT_DEPTH - 1) ? '0 : orptr_q + OPTR_W'(1);
			end
			ocnt_q <= ocnt_q + OCNT_W'(step) - OCNT_W'(out_pop);
		end
	end

	a_carry_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && item_s1.last_col |=> carry_q == '0)
		else $error("carried error not cleared at row end");

	a_pending_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && item_s1.last_col |=> pb0_q == '0 && pb1_q == '0)
		else $error("pending below errors not cleared at row end");

	a_pend_flush: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q && !wr_behind && !creating |=> !pend_v_q)
		else $error("held last-column write not flushed on free port");

	a_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !q_pop |=> $stable(rd_data_s1) && $stable(fwd_s1))
		else $error("stalled stage lost its read data");

	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q == OCNT_W'(OUT_DEPTH) |-> !step)
		else $error("result buffer overrun");

endmodule

>>> hw/rtl/floyd_steinberg_halftoner.sv
// Serpentine Floyd-Steinberg halftoner: push one 8-bit grey pixel per clock
// while full is low (even rows left to right, odd rows right to left) and pop
// one result per pixel (white, row_end, frame_end) in the same order.
// Sustained rate is one pixel per clock while results are popped; each pixel
// is held in the queue, stage 1 and the result buffer. The per-clock limit is
// the carried error loop (add, clamp, threshold, 7/16 share) in the back
// stage. Row errors live in a MAX_WIDTH-entry memory not cleared after reset;
// row 0 never reads it. The user must write image_width and image_height (cfg
// index 0 and 1) while no pixel is in flight; the block does not enforce it.
module floyd_steinberg_halftoner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [7:0]                          pixel,
	output logic                                empty,
	input  logic                                pop,
	output logic                                white,
	output logic                                row_end,
	output logic                                frame_end,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fsh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fsh_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import fsh_pkg::*;

	logic [WIDTH_W-1:0]  image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;
	logic                accept;
	item_t               front_item;
	item_t               q_head;
	logic                q_empty;
	logic                q_pop;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	fsh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.pixel        (pixel),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.item         (front_item)
	);

	fsh_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push),
		.wr_item (front_item),
		.rd      (q_pop),
		.full    (full),
		.empty   (q_empty),
		.head    (q_head)
	);

	fsh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.white     (white),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

endmodule
